### rtl/ffc_pkg.sv
// Types, codes and constants shared by the Fletcher frame checker modules.
package ffc_pkg;

    localparam logic [7:0] MAX_LEN_RESET = 8'd200;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK_A,
        PH_CHECK_B,
        PH_DISCARD
    } ffc_phase_t;

    typedef enum logic [1:0] {
        ST_VALID,
        ST_TOO_LONG,
        ST_BAD_SUM
    } ffc_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } ffc_in_t;

    typedef struct packed {
        logic        frame_ok;
        ffc_status_t frame_status;
        logic [7:0]  frame_command;
        logic [7:0]  frame_length;
    } ffc_out_t;

endpackage

### rtl/ffc_input_stage.sv
// Input register that holds one received byte until the checker consumes it.
module ffc_input_stage
    import ffc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  ffc_in_t s_data,
    input  logic    out_space,
    output logic    advance,
    output ffc_in_t item
);

    logic    in_valid_reg;
    logic    in_valid_next;
    ffc_in_t in_data_reg;

    assign advance = in_valid_reg && out_space;
    assign s_ready = !in_valid_reg || advance;
    assign item    = in_data_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

endmodule

### rtl/ffc_checker_core.sv
// Frame state machine with the two running Fletcher sums and the length check.
module ffc_checker_core
    import ffc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  ffc_in_t    item,
    input  logic [7:0] max_len,
    output logic       res_valid,
    output ffc_out_t   res
);

    ffc_phase_t phase_reg;
    ffc_phase_t phase_next;
    logic [7:0] sum_first_reg;
    logic [7:0] sum_first_next;
    logic [7:0] sum_second_reg;
    logic [7:0] sum_second_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic [7:0] held_command_reg;
    logic [7:0] held_command_next;
    logic [7:0] held_length_reg;
    logic [7:0] held_length_next;
    logic [7:0] check_first_reg;
    logic [7:0] check_first_next;
    logic [7:0] acc_first;
    logic [7:0] acc_second;
    logic       too_long;
    logic       sums_match;

    assign acc_first  = sum_first_reg + item.data_byte;
    assign acc_second = sum_second_reg + acc_first;
    assign too_long   = item.data_byte > max_len;
    assign sums_match = (check_first_reg == sum_first_reg)
                        && (item.data_byte == sum_second_reg);

    always_comb begin
        phase_next = phase_reg;
        if (advance) begin
            if (item.frame_start) begin
                phase_next = PH_LENGTH;
            end else begin
                case (phase_reg)
                    PH_LENGTH: begin
                        if (too_long) begin
                            phase_next = PH_DISCARD;
                        end else if (item.data_byte == 8'd0) begin
                            phase_next = PH_CHECK_A;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (bytes_left_reg == 8'd1) begin
                            phase_next = PH_CHECK_A;
                        end
                    end
                    PH_CHECK_A: phase_next = PH_CHECK_B;
                    PH_CHECK_B: phase_next = PH_IDLE;
                    default:    phase_next = phase_reg;
                endcase
            end
        end
    end

    always_comb begin
        sum_first_next    = sum_first_reg;
        sum_second_next   = sum_second_reg;
        bytes_left_next   = bytes_left_reg;
        held_command_next = held_command_reg;
        held_length_next  = held_length_reg;
        check_first_next  = check_first_reg;
        res_valid         = 1'b0;
        res.frame_ok      = 1'b0;
        res.frame_status  = ST_VALID;
        res.frame_command = held_command_reg;
        res.frame_length  = held_length_reg;
        if (advance) begin
            if (item.frame_start) begin
                held_command_next = item.data_byte;
                held_length_next  = 8'd0;
                bytes_left_next   = 8'd0;
                check_first_next  = 8'd0;
                sum_first_next    = item.data_byte;
                sum_second_next   = item.data_byte;
            end else begin
                case (phase_reg)
                    PH_LENGTH: begin
                        held_length_next = item.data_byte;
                        sum_first_next   = acc_first;
                        sum_second_next  = acc_second;
                        res.frame_length = item.data_byte;
                        if (too_long) begin
                            res_valid        = 1'b1;
                            res.frame_status = ST_TOO_LONG;
                        end else begin
                            bytes_left_next = item.data_byte;
                        end
                    end
                    PH_PAYLOAD: begin
                        sum_first_next  = acc_first;
                        sum_second_next = acc_second;
                        bytes_left_next = bytes_left_reg - 8'd1;
                    end
                    PH_CHECK_A: begin
                        check_first_next = item.data_byte;
                    end
                    PH_CHECK_B: begin
                        res_valid        = 1'b1;
                        res.frame_ok     = sums_match;
                        res.frame_status = sums_match ? ST_VALID : ST_BAD_SUM;
                    end
                    default: begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            sum_first_reg    <= 8'd0;
            sum_second_reg   <= 8'd0;
            bytes_left_reg   <= 8'd0;
            held_command_reg <= 8'd0;
            held_length_reg  <= 8'd0;
            check_first_reg  <= 8'd0;
        end else begin
            phase_reg        <= phase_next;
            sum_first_reg    <= sum_first_next;
            sum_second_reg   <= sum_second_next;
            bytes_left_reg   <= bytes_left_next;
            held_command_reg <= held_command_next;
            held_length_reg  <= held_length_next;
            check_first_reg  <= check_first_next;
        end
    end

endmodule

### rtl/ffc_output_stage.sv
// Result register that holds one frame verdict until the receiver takes it.
module ffc_output_stage
    import ffc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     res_valid,
    input  ffc_out_t res,
    output logic     out_space,
    output logic     m_valid,
    input  logic     m_ready,
    output ffc_out_t m_data
);

    logic     out_valid_reg;
    logic     out_valid_next;
    ffc_out_t out_data_reg;

    assign out_space = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_comb begin
        if (res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_data_reg <= res;
        end
    end

endmodule

### rtl/fletcher_frame_checker.sv
// Top level of the Fletcher frame checker with its configuration register.
//
//   Channel  Ports                          Moves
//   input    s_valid  s_ready  s_data       one stream byte and its start flag
//   result   m_valid  m_ready  m_data       one verdict for a frame
//   config   cfg_valid cfg_ready cfg_data   the maximum payload length
//
// A byte is taken into the input register and processed once the result register has
// space; its verdict, if any, is registered there and then appears on the result port.
// One byte is accepted in every cycle while the result side keeps up; a stalled
// result holds the input register, which in turn holds back s_ready.
// Reset empties both registers, returns the checker to idle and sets the limit
// to 200. Configuration transfers are always accepted, as cfg_ready is tied high.
module fletcher_frame_checker
    import ffc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ffc_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output ffc_out_t   m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic       out_space;
    logic       advance;
    ffc_in_t    item;
    logic       res_valid;
    ffc_out_t   res;
    logic [7:0] max_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_data;
        end
    end

    ffc_input_stage u_input (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_space (out_space),
        .advance   (advance),
        .item      (item)
    );

    ffc_checker_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ffc_output_stage u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_space (out_space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
